// File: rtl/core/lc3b_pkg.sv
// Package for the LC-3b instruction execute block: opcodes, commands, helpers.
// No dependencies.
`default_nettype none
package lc3b_pkg;
   localparam int MemWordsDefault = 32768;
   localparam int DataW = 16;

   typedef enum logic [3:0] {
      OPC_BR = 4'd0, OPC_ADD = 4'd1, OPC_LDB = 4'd2, OPC_STB = 4'd3,
      OPC_JSR = 4'd4, OPC_AND = 4'd5, OPC_LDW = 4'd6, OPC_STW = 4'd7,
      OPC_RTI = 4'd8, OPC_XOR = 4'd9, OPC_U10 = 4'd10, OPC_U11 = 4'd11,
      OPC_JMP = 4'd12, OPC_SHF = 4'd13, OPC_LEA = 4'd14, OPC_TRAP = 4'd15
   } opcode_type;

   // controller to datapath commands
   typedef struct packed {
      logic       clear_step;   // write zero at clear address
      logic       take_item;    // latch input item
      logic       fetch;        // memory read at PC, or preload write at load address
      logic       execute;      // decode and run (first half)
      logic       finish;       // second memory access + commit
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic item_is_exec;
   } status_type;

   function automatic logic [15:0] sext5(input logic [15:0] v);
      sext5 = {{11{v[4]}}, v[4:0]};
   endfunction
   function automatic logic [15:0] sext6(input logic [15:0] v);
      sext6 = {{10{v[5]}}, v[5:0]};
   endfunction
   function automatic logic [15:0] sext9(input logic [15:0] v);
      sext9 = {{7{v[8]}}, v[8:0]};
   endfunction
   function automatic logic [15:0] sext11(input logic [15:0] v);
      sext11 = {{5{v[10]}}, v[10:0]};
   endfunction
endpackage
`default_nettype wire

// File: rtl/core/lc3b_if.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on nothing.
`default_nettype none
interface lc3b_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [14:0] load_addr;
   logic [15:0] load_data;
   modport source (output valid, op, load_addr, load_data, input ready);
   modport sink (input valid, op, load_addr, load_data, output ready);
endinterface

interface lc3b_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pc_now;
   logic        flag_n;
   logic        flag_z;
   logic        flag_p;
   logic        is_halted;
   logic        reg_written;
   logic [2:0]  reg_index;
   logic [15:0] reg_value;
   logic        mem_written;
   logic [15:0] mem_byte_addr;
   logic [15:0] mem_value;
   logic        mem_is_byte;
   modport source (output valid, pc_now, flag_n, flag_z, flag_p, is_halted, reg_written,
      reg_index, reg_value, mem_written, mem_byte_addr, mem_value, mem_is_byte,
      input ready);
   modport sink (input valid, pc_now, flag_n, flag_z, flag_p, is_halted, reg_written,
      reg_index, reg_value, mem_written, mem_byte_addr, mem_value, mem_is_byte,
      output ready);
endinterface
`default_nettype wire

// File: rtl/core/lc3b_ctrl.sv
// Sequencer for the LC-3b block: clearing pass, item intake, fetch, execute, finish.
// Depends on lc3b_pkg.
`default_nettype none
module lc3b_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   out_free,
   input  wire lc3b_pkg::status_type   status,
   output lc3b_pkg::cmd_type           cmd
);
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_FETCH, S_EXEC, S_FINISH
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (status.clear_done) state_in = S_IDLE;
         S_IDLE: if (req_valid && out_free) state_in = S_FETCH;
         S_FETCH: state_in = status.item_is_exec ? S_EXEC : S_FINISH;
         S_EXEC: state_in = S_FINISH;
         S_FINISH: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_IDLE) && out_free;

   always_comb begin
      cmd = '0;
      cmd.clear_step = (state_ff == S_CLEAR);
      cmd.take_item  = req_ready && req_valid;
      cmd.fetch      = (state_ff == S_FETCH);
      cmd.execute    = (state_ff == S_EXEC);
      cmd.finish     = (state_ff == S_FINISH);
   end
endmodule
`default_nettype wire

// File: rtl/core/lc3b_dpath.sv
// Datapath: word memory, register file, PC, condition codes and result register.
// Depends on lc3b_pkg.
`default_nettype none
module lc3b_dpath #(
   parameter int MEM_WORDS = lc3b_pkg::MemWordsDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lc3b_pkg::cmd_type    cmd,
   output lc3b_pkg::status_type      status,
   input  wire logic                 in_op,
   input  wire logic [14:0]          in_load_addr,
   input  wire logic [15:0]          in_load_data,
   input  wire logic                 cfg_we,
   input  wire logic [15:0]          cfg_data,
   output logic [15:0]               start_pc,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic                      out_free,
   output logic [15:0]               o_pc,
   output logic                      o_n,
   output logic                      o_z,
   output logic                      o_p,
   output logic                      o_halt,
   output logic                      o_rw,
   output logic [2:0]                o_ridx,
   output logic [15:0]               o_rval,
   output logic                      o_mw,
   output logic [15:0]               o_maddr,
   output logic [15:0]               o_mval,
   output logic                      o_mbyte
);
   localparam int AW = $clog2(MEM_WORDS);

   logic [15:0] mem [MEM_WORDS];
   logic [15:0] rdata_ff;
   logic        rok_ff;      // last read hit a word inside memory

   logic [AW-1:0] clr_ff;
   logic          clr_done_ff;
   logic          op_ff;
   logic [14:0]   laddr_ff;
   logic [15:0]   ldata_ff;
   logic [15:0]   pc_ff, spc_ff;
   logic          n_ff, z_ff, p_ff;
   logic [15:0]   rf_ff [8];
   logic          halt_ff;
   // execute-stage registers
   logic [15:0]   ea_ff;       // effective byte address of data access or trap vector
   logic [15:0]   val_ff;      // register value (alu) or store data
   logic [15:0]   next_ff;
   logic          rw_ff, mw_ff, mbyte_ff, ld_ff, ldb_ff, trap_ff, setcc_ff;
   logic [2:0]    ridx_ff;

   // memory port address and write controls
   logic [15:0]   mbyte_addr;  // byte address
   logic          m_we;
   logic [15:0]   m_wdata;
   logic [15:0]   rd_word;
   logic [15:0]   mword;
   logic          in_range;
   logic [AW-1:0] widx;
   logic [15:0]   bs_word;

   // decode signals
   logic [15:0] inst;
   logic [3:0]  opc;
   logic [2:0]  dr, sr1;
   logic [15:0] a, b, off6, pc2, sh, s9, s11, off6x2, off9x2, off11x2;

   // execute results
   logic        ex_rw, ex_mw, ex_mbyte, ex_ld, ex_ldb, ex_trap, ex_setcc;
   logic [2:0]  ex_ridx;
   logic [15:0] ex_val, ex_ea, ex_next;

   // commit view
   logic        commit, wr_reg, wr_mem, cc_upd;
   logic [15:0] ldv, wv, npc, pc_in;
   logic        n_in, z_in, p_in;

   assign status.clear_done   = clr_done_ff;
   assign status.item_is_exec = op_ff;
   assign start_pc = spc_ff;
   assign out_free = !out_valid || out_ready;

   // read data outside memory reads as zero
   assign rd_word = rok_ff ? rdata_ff : 16'd0;

   // decode of the fetched word (valid in EXEC)
   assign inst = rd_word;
   assign opc = inst[15:12];
   assign dr = inst[11:9];
   assign sr1 = inst[8:6];
   assign a = rf_ff[sr1];
   assign b = inst[5] ? lc3b_pkg::sext5(inst) : rf_ff[inst[2:0]];
   assign off6 = lc3b_pkg::sext6(inst);
   assign s9 = lc3b_pkg::sext9(inst);
   assign s11 = lc3b_pkg::sext11(inst);
   assign off6x2 = {off6[14:0], 1'b0};
   assign off9x2 = {s9[14:0], 1'b0};
   assign off11x2 = {s11[14:0], 1'b0};
   assign pc2 = pc_ff + 16'd2;

   always_comb begin
      case (inst[5:4])
         2'd0: sh = a << inst[3:0];
         2'd1: sh = a >> inst[3:0];
         2'd3: sh = 16'($signed(a) >>> inst[3:0]);
         default: sh = a;
      endcase
   end

   // execute: results and data access address
   always_comb begin
      ex_rw = 1'b0; ex_mw = 1'b0; ex_mbyte = 1'b0; ex_ld = 1'b0; ex_ldb = 1'b0;
      ex_trap = 1'b0; ex_setcc = 1'b0;
      ex_ridx = dr; ex_val = '0; ex_ea = '0; ex_next = pc2;
      unique case (lc3b_pkg::opcode_type'(opc))
         lc3b_pkg::OPC_ADD: begin
            ex_rw = 1'b1; ex_setcc = 1'b1; ex_val = a + b;
         end
         lc3b_pkg::OPC_AND: begin
            ex_rw = 1'b1; ex_setcc = 1'b1; ex_val = a & b;
         end
         lc3b_pkg::OPC_XOR: begin
            ex_rw = 1'b1; ex_setcc = 1'b1; ex_val = a ^ b;
         end
         lc3b_pkg::OPC_SHF: begin
            ex_rw = 1'b1; ex_setcc = 1'b1; ex_val = sh;
         end
         lc3b_pkg::OPC_LDB: begin
            ex_rw = 1'b1; ex_setcc = 1'b1; ex_ld = 1'b1; ex_ldb = 1'b1;
            ex_ea = a + off6;
         end
         lc3b_pkg::OPC_LDW: begin
            ex_rw = 1'b1; ex_setcc = 1'b1; ex_ld = 1'b1;
            ex_ea = a + off6x2;
         end
         lc3b_pkg::OPC_BR: begin
            if ((inst[11] && n_ff) || (inst[10] && z_ff) || (inst[9] && p_ff))
               ex_next = pc2 + off9x2;
         end
         lc3b_pkg::OPC_JMP: ex_next = a;
         lc3b_pkg::OPC_JSR: begin
            ex_rw = 1'b1; ex_ridx = 3'd7; ex_val = pc2;
            ex_next = inst[11] ? pc2 + off11x2 : a;
         end
         lc3b_pkg::OPC_LEA: begin
            ex_rw = 1'b1;
            ex_val = pc2 + off9x2;
         end
         lc3b_pkg::OPC_TRAP: begin
            ex_rw = 1'b1; ex_ridx = 3'd7; ex_val = pc2; ex_trap = 1'b1;
            ex_ea = {7'd0, inst[7:0], 1'b0};
         end
         lc3b_pkg::OPC_STB: begin
            ex_mw = 1'b1; ex_mbyte = 1'b1;
            ex_ea = a + off6; ex_val = {8'd0, rf_ff[dr][7:0]};
         end
         lc3b_pkg::OPC_STW: begin
            ex_mw = 1'b1;
            ex_ea = (a + off6x2) & 16'hFFFE;
            ex_val = rf_ff[dr];
         end
         default: ;
      endcase
   end

   // one address per cycle on the single port: fetch or preload, then data read
   // in EXEC, then the store in FINISH
   always_comb begin
      mbyte_addr = pc_ff;
      if (cmd.fetch && !op_ff) mbyte_addr = {laddr_ff, 1'b0};
      else if (cmd.execute) mbyte_addr = ex_ea;
      else if (cmd.finish) mbyte_addr = ea_ff;
   end
   assign mword = {1'b0, mbyte_addr[15:1]};
   assign in_range = (32'(mword) < 32'(MEM_WORDS));
   assign widx = mword[AW-1:0];

   assign commit = cmd.finish && op_ff && !halt_ff;
   assign wr_reg = commit && rw_ff;
   assign wr_mem = commit && mw_ff;

   // byte store merges into the word read during EXEC
   assign bs_word = ea_ff[0] ? {val_ff[7:0], rd_word[7:0]} : {rd_word[15:8], val_ff[7:0]};

   // writes: preload during fetch slot, stores in finish slot
   always_comb begin
      m_we = 1'b0;
      m_wdata = ldata_ff;
      if (cmd.fetch && !op_ff) m_we = 1'b1;
      else if (wr_mem) begin
         m_we = 1'b1;
         m_wdata = mbyte_ff ? bs_word : val_ff;
      end
   end

   // memory (clear pass, reads and writes)
   always_ff @(posedge clock) begin
      if (cmd.clear_step) mem[clr_ff] <= '0;
      else if (m_we && in_range) mem[widx] <= m_wdata;
      rdata_ff <= mem[widx];
      rok_ff <= in_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         clr_done_ff <= 1'b0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
         if (32'(clr_ff) == 32'(MEM_WORDS - 1)) clr_done_ff <= 1'b1;
      end
   end

   // item latch
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         op_ff <= in_op;
         laddr_ff <= in_load_addr;
         ldata_ff <= in_load_data;
      end
   end

   // execute-stage registers
   always_ff @(posedge clock) begin
      if (cmd.fetch) halt_ff <= op_ff && (pc_ff == 16'd0);
      if (cmd.execute) begin
         rw_ff <= ex_rw; mw_ff <= ex_mw; mbyte_ff <= ex_mbyte;
         ld_ff <= ex_ld; ldb_ff <= ex_ldb; trap_ff <= ex_trap; setcc_ff <= ex_setcc;
         ridx_ff <= ex_ridx; val_ff <= ex_val; ea_ff <= ex_ea; next_ff <= ex_next;
      end
   end

   // load data and trap vector arrive from the EXEC read
   always_comb begin
      if (ldb_ff) ldv = ea_ff[0] ? {{8{rd_word[15]}}, rd_word[15:8]}
                                 : {{8{rd_word[7]}}, rd_word[7:0]};
      else ldv = rd_word;
   end
   assign wv = ld_ff ? ldv : val_ff;
   assign npc = trap_ff ? rd_word : next_ff;

   // next PC and condition codes
   assign cc_upd = commit && setcc_ff;
   assign n_in = cc_upd ? wv[15] : n_ff;
   assign z_in = cc_upd ? (wv == 16'd0) : z_ff;
   assign p_in = cc_upd ? (!wv[15] && (wv != 16'd0)) : p_ff;
   always_comb begin
      pc_in = pc_ff;
      if (cfg_we) pc_in = cfg_data;
      else if (commit) pc_in = npc;
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0; spc_ff <= '0;
         n_ff <= 1'b0; z_ff <= 1'b1; p_ff <= 1'b0;
         for (int i = 0; i < 8; i++) rf_ff[i] <= '0;
         out_valid <= 1'b0;
      end else begin
         pc_ff <= pc_in;
         n_ff <= n_in; z_ff <= z_in; p_ff <= p_in;
         if (cfg_we) spc_ff <= cfg_data;
         if (wr_reg) rf_ff[ridx_ff] <= wv;
         out_valid <= cmd.finish || (out_valid && !out_ready);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         o_pc <= pc_in; o_n <= n_in; o_z <= z_in; o_p <= p_in;
         o_halt <= halt_ff;
         o_rw <= wr_reg;
         o_ridx <= wr_reg ? ridx_ff : 3'd0;
         o_rval <= wr_reg ? wv : 16'd0;
         o_mw <= !op_ff || wr_mem;
         o_maddr <= !op_ff ? {laddr_ff, 1'b0} : (wr_mem ? ea_ff : 16'd0);
         o_mval <= !op_ff ? ldata_ff : (wr_mem ? val_ff : 16'd0);
         o_mbyte <= wr_mem && mbyte_ff;
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/lc3b_instruction_execute.sv
// Top level of the LC-3b instruction execute block; ties sequencer and datapath.
// Depends on lc3b_pkg, lc3b_if, lc3b_ctrl, lc3b_dpath.
//
// One beat either preloads a memory word (intake, fetch, finish) or runs one
// instruction (intake, fetch, execute, finish); the single memory port serves
// the fetch and then one data access. After reset a clearing pass zeroes
// memory; no beat is accepted until it ends. Writing start_pc also loads the
// program counter.
`default_nettype none
module lc3b_instruction_execute #(
   parameter int MEM_WORDS = lc3b_pkg::MemWordsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   lc3b_req_if.sink         req,
   lc3b_rsp_if.source       rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   lc3b_pkg::cmd_type    cmd;
   lc3b_pkg::status_type status;
   logic out_free;
   logic cfg_we;
   logic [15:0] spc;

   assign csr_pready = 1'b1;
   assign cfg_we = csr_psel && csr_penable && csr_pwrite && (csr_paddr == 2'd0);
   assign csr_prdata = (csr_paddr == 2'd0) ? {16'd0, spc} : 32'd0;

   lc3b_ctrl u_ctrl (
      .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
      .out_free, .status, .cmd
   );

   lc3b_dpath #(.MEM_WORDS(MEM_WORDS)) u_dpath (
      .clock, .reset, .cmd, .status,
      .in_op(req.op), .in_load_addr(req.load_addr), .in_load_data(req.load_data),
      .cfg_we, .cfg_data(csr_pwdata[15:0]), .start_pc(spc),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_free,
      .o_pc(rsp.pc_now), .o_n(rsp.flag_n), .o_z(rsp.flag_z), .o_p(rsp.flag_p),
      .o_halt(rsp.is_halted), .o_rw(rsp.reg_written), .o_ridx(rsp.reg_index),
      .o_rval(rsp.reg_value), .o_mw(rsp.mem_written), .o_maddr(rsp.mem_byte_addr),
      .o_mval(rsp.mem_value), .o_mbyte(rsp.mem_is_byte)
   );
endmodule
`default_nettype wire

// File: rtl/core/lc3b_checker.sv
// Port-level checker for lc3b_instruction_execute, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module lc3b_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_is_halted,
   input wire logic        rsp_reg_written,
   input wire logic        rsp_mem_written,
   input wire logic        rsp_flag_n,
   input wire logic        rsp_flag_z,
   input wire logic        rsp_flag_p
);
   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   // flags are one-hot on every beat
   a_cc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_flag_n, rsp_flag_z, rsp_flag_p})) else $error("cc");
   // halted beat writes nothing
   a_halt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_halted |-> !rsp_reg_written && !rsp_mem_written)
      else $error("halt wrote");
   // no new intake right after one
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("double intake");
endmodule

bind lc3b_instruction_execute lc3b_checker u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_is_halted(rsp.is_halted),
   .rsp_reg_written(rsp.reg_written), .rsp_mem_written(rsp.mem_written),
   .rsp_flag_n(rsp.flag_n), .rsp_flag_z(rsp.flag_z), .rsp_flag_p(rsp.flag_p)
);
`default_nettype wire

// File: tb/sv/tb_lc3b_checker.sv
// Scoreboard for lc3b_instruction_execute: mirrors the core state, predicts each
// response beat and compares it. Depends on lc3b_pkg and lc3b_if.
`timescale 1ns / 1ps
module tb_lc3b_checker #(
   parameter int MEM_WORDS = lc3b_pkg::MemWordsDefault
) (
   input  logic        clock,
   input  logic        reset,
   lc3b_req_if.sink    req,
   lc3b_rsp_if.sink    rsp,
   input  logic        cfg_wr,
   input  logic [15:0] cfg_pc,
   output int          fail_count,
   output int          pending
);
   import lc3b_pkg::*;

   typedef struct packed {
      logic [15:0] pc;
      logic        n, z, p, halted, rw;
      logic [2:0]  ridx;
      logic [15:0] rval;
      logic        mw;
      logic [15:0] maddr, mval;
      logic        mbyte;
   } outcome_t;

   logic [15:0] mem_img [MEM_WORDS];
   logic [15:0] regs [8];
   logic [15:0] pc_q;
   logic        cn, cz, cp;
   outcome_t    expected_q [$];

   function automatic logic [15:0] rd_word(logic [15:0] w);
      return (w < MEM_WORDS) ? mem_img[w] : 16'h0000;
   endfunction

   function automatic logic [15:0] sx(logic [15:0] v, int bits);
      logic [15:0] m;
      m = (16'h1 << bits) - 16'h1;
      v = v & m;
      if (v[bits-1]) v = v | ~m;
      return v;
   endfunction

   function automatic void set_codes(logic [15:0] v);
      cn = v[15];
      cz = (v == 16'h0);
      cp = !cn && !cz;
   endfunction

   // execute one beat on the shadow state
   function automatic outcome_t run_beat(logic op, logic [14:0] la, logic [15:0] ld);
      outcome_t o;
      logic [15:0] inst, pc2, a, b, off6, nxt, v, ad, w;
      opcode_type opc;
      logic [2:0] dr;
      o = '0;
      if (!op) begin
         if (la < MEM_WORDS) mem_img[la] = ld;
         o.mw = 1; o.maddr = {la, 1'b0}; o.mval = ld;
      end else if (pc_q == 16'h0) begin
         o.halted = 1;
      end else begin
         inst = rd_word({1'b0, pc_q[15:1]});
         pc2 = pc_q + 16'd2;
         opc = opcode_type'(inst[15:12]);
         dr = inst[11:9];
         a = regs[inst[8:6]];
         b = inst[5] ? sx(inst, 5) : regs[inst[2:0]];
         off6 = sx(inst, 6);
         nxt = pc2;
         case (opc)
            OPC_ADD, OPC_AND, OPC_XOR, OPC_LDB, OPC_LDW, OPC_SHF: begin
               case (opc)
                  OPC_ADD: v = a + b;
                  OPC_AND: v = a & b;
                  OPC_XOR: v = a ^ b;
                  OPC_LDB: begin
                     ad = a + off6;
                     w = rd_word({1'b0, ad[15:1]});
                     v = sx(ad[0] ? (w >> 8) : w, 8);
                  end
                  OPC_LDW: begin
                     ad = a + (off6 << 1);
                     v = rd_word({1'b0, ad[15:1]});
                  end
                  default: begin
                     case (inst[5:4])
                        2'd0: v = a << inst[3:0];
                        2'd1: v = a >> inst[3:0];
                        2'd3: v = $unsigned($signed(a) >>> inst[3:0]);
                        default: v = a;
                     endcase
                  end
               endcase
               regs[dr] = v;
               set_codes(v);
               o.rw = 1; o.ridx = dr; o.rval = v;
            end
            OPC_BR:
               if ((inst[11] && cn) || (inst[10] && cz) || (inst[9] && cp))
                  nxt = pc2 + (sx(inst, 9) << 1);
            OPC_JMP: nxt = a;
            OPC_JSR: begin
               nxt = inst[11] ? pc2 + (sx(inst, 11) << 1) : a;
               regs[7] = pc2;
               o.rw = 1; o.ridx = 3'd7; o.rval = pc2;
            end
            OPC_LEA: begin
               v = pc2 + (sx(inst, 9) << 1);
               regs[dr] = v;
               o.rw = 1; o.ridx = dr; o.rval = v;
            end
            OPC_TRAP: begin
               nxt = rd_word({8'h0, inst[7:0]});
               regs[7] = pc2;
               o.rw = 1; o.ridx = 3'd7; o.rval = pc2;
            end
            OPC_STB: begin
               ad = a + off6;
               v = {8'h0, regs[dr][7:0]};
               if (ad[15:1] < MEM_WORDS) begin
                  if (ad[0]) mem_img[ad[15:1]][15:8] = v[7:0];
                  else mem_img[ad[15:1]][7:0] = v[7:0];
               end
               o.mw = 1; o.mbyte = 1; o.maddr = ad; o.mval = v;
            end
            OPC_STW: begin
               ad = (a + (off6 << 1)) & 16'hFFFE;
               if (ad[15:1] < MEM_WORDS) mem_img[ad[15:1]] = regs[dr];
               o.mw = 1; o.maddr = ad; o.mval = regs[dr];
            end
            default: ;
         endcase
         pc_q = nxt;
      end
      o.pc = pc_q; o.n = cn; o.z = cz; o.p = cp;
      return o;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      outcome_t got, exp_o;
      if (reset) begin
         foreach (mem_img[i]) mem_img[i] = 16'h0;
         foreach (regs[i]) regs[i] = 16'h0;
         pc_q = 16'h0; cn = 0; cz = 1; cp = 0;
         fail_count = 0;
         expected_q.delete();
      end else begin
         if (cfg_wr) pc_q = cfg_pc;
         if (req.valid && req.ready)
            expected_q.push_back(run_beat(req.op, req.load_addr, req.load_data));
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.pc_now, rsp.flag_n, rsp.flag_z, rsp.flag_p, rsp.is_halted,
                    rsp.reg_written, rsp.reg_index, rsp.reg_value, rsp.mem_written,
                    rsp.mem_byte_addr, rsp.mem_value, rsp.mem_is_byte};
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response beat %h", got);
            end else begin
               exp_o = expected_q.pop_front();
               if (got !== exp_o) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp pc=%h nzp=%b%b%b h=%b r=%b/%0d/%h m=%b/%h/%h/%b",
                        exp_o.pc, exp_o.n, exp_o.z, exp_o.p, exp_o.halted, exp_o.rw,
                        exp_o.ridx, exp_o.rval, exp_o.mw, exp_o.maddr, exp_o.mval,
                        exp_o.mbyte, "\n          got pc=%h nzp=%b%b%b h=%b r=%b/%0d/%h",
                        got.pc, got.n, got.z, got.p, got.halted, got.rw, got.ridx,
                        got.rval, " m=%b/%h/%h/%b", got.mw, got.maddr, got.mval,
                        got.mbyte);
               end
            end
         end
      end
   end
endmodule

// File: tb/sv/tb.sv
// Top of the lc3b_instruction_execute testbench: clock, reset, program stimulus,
// start_pc writes and verdict. Depends on lc3b_pkg, lc3b_if, the DUT and tb_lc3b_checker.
`timescale 1ns / 1ps
module tb;
   import lc3b_pkg::*;

   localparam int WATCHDOG = 200000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        cfg_wr;
   int          fail_count, pending, idle_cycles;
   int          idle_pct = 28;
   bit          timed_out = 0;

   lc3b_req_if req ();
   lc3b_rsp_if rsp ();

   lc3b_instruction_execute dut (
      .clock, .reset, .req(req.sink), .rsp(rsp.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready);

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   tb_lc3b_checker chk (
      .clock, .reset, .req(req.sink), .rsp(rsp.sink), .cfg_wr,
      .cfg_pc(csr_pwdata[15:0]), .fail_count, .pending);

   always #2 clock = ~clock;

   // response stall
   always @(posedge clock)
      rsp.ready <= reset ? 1'b0 : ($urandom_range(99) >= idle_pct);

   // watchdog: cycles with no beat accepted on either side
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG && !timed_out) begin
         timed_out = 1;
         $display("lc3b_instruction_execute test failed");
         $finish;
      end
   end

   // valid stays up between back-to-back beats; drain drops it
   task automatic send(logic op, logic [14:0] la, logic [15:0] ld);
      while ($urandom_range(99) < idle_pct) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1; req.op <= op; req.load_addr <= la; req.load_data <= ld;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic preload(logic [14:0] wa, logic [15:0] w);
      send(0, wa, w);
   endtask

   task automatic step();
      send(1, 15'($urandom), 16'($urandom));
   endtask

   task automatic drain();
      req.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_start_pc(logic [15:0] v);
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= 2'd0; csr_pwdata <= {16'h0, v};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
   endtask

   // random instruction; about one in ten gets the RTI opcode
   function automatic logic [15:0] rand_inst();
      logic [15:0] i;
      i = 16'($urandom);
      if ($urandom_range(9) == 0) i[15:12] = OPC_RTI;
      return i;
   endfunction

   initial begin
      int i, k;
      logic [15:0] base;
      req.valid = 0; req.op = 0; req.load_addr = '0; req.load_data = '0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: halted, preload extremes, each opcode but JMP, RTI and U11
      step();
      preload(15'h7FFF, 16'hFFFF);
      preload(15'h0000, 16'h0000);
      drain();
      write_start_pc(16'h0100);
      preload(15'h0080, {OPC_ADD, 3'd1, 3'd0, 1'b1, 5'h10});   // R1 = -16
      preload(15'h0081, {OPC_AND, 3'd2, 3'd1, 1'b0, 2'b0, 3'd1});
      preload(15'h0082, {OPC_XOR, 3'd3, 3'd1, 1'b1, 5'h1F});   // NOT
      preload(15'h0083, {OPC_SHF, 3'd4, 3'd1, 2'd3, 4'd15});
      preload(15'h0084, {OPC_SHF, 3'd4, 3'd1, 2'd2, 4'd3});
      preload(15'h0085, {OPC_STB, 3'd1, 3'd0, 6'h21});
      preload(15'h0086, {OPC_STW, 3'd1, 3'd0, 6'h1F});
      preload(15'h0087, {OPC_LDB, 3'd5, 3'd0, 6'h21});
      preload(15'h0088, {OPC_LDW, 3'd6, 3'd0, 6'h1F});
      preload(15'h0089, {OPC_LEA, 3'd7, 9'h1FF});
      preload(15'h008A, {OPC_BR, 3'b000, 9'h0FF});
      preload(15'h008B, {OPC_BR, 3'b111, 9'h000});
      preload(15'h008C, {OPC_U10, 12'hFFF});
      preload(15'h008D, {OPC_JSR, 1'b1, 11'h001});
      preload(15'h008F, {OPC_TRAP, 4'h0, 8'h40});
      preload(15'h0040, 16'h0120);
      preload(15'h0090, {OPC_JSR, 1'b0, 2'b0, 3'd7, 6'h0});
      for (i = 0; i < 17; i++) step();
      drain();

      // random: short programs with random content, mixed with preload noise
      for (k = 0; k < 43; k++) begin
         idle_pct = (k % 8 == 3) ? 0 : 28;
         base = (k == 5) ? 16'hFFFE : {8'($urandom_range(1, 255)), 8'h0};
         if (k == 7) base = 16'h0002;
         write_start_pc(base);
         for (i = 0; i < 10; i++) preload(base[15:1] + 15'(i), rand_inst());
         for (i = 0; i < 16; i++) begin
            if ($urandom_range(9) == 0) preload(15'($urandom), 16'($urandom));
            else step();
         end
         drain();
      end

      if (fail_count == 0)
         $display("lc3b_instruction_execute test passed");
      else
         $display("lc3b_instruction_execute test failed");
      $finish;
   end
endmodule

// File: filelist.f
rtl/core/lc3b_pkg.sv
rtl/core/lc3b_if.sv
rtl/core/lc3b_ctrl.sv
rtl/core/lc3b_dpath.sv
rtl/core/lc3b_instruction_execute.sv
rtl/core/lc3b_checker.sv
tb/sv/tb_lc3b_checker.sv
tb/sv/tb.sv
